### hdl/calendar_clock_counter_core_defines.svh
// ----------------------------------------------------------------------------
// Calendar clock counter assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_COUNTER_CORE_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_CORE_DEFINES_SVH

// same-cycle implication
`define CCC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar clock counter package
// Time-of-day type, calendar limits, reset values and month lengths.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int TPS_W      = 16;
    localparam int M_TDATA_W  = 48;
    localparam int S_TDATA_W  = 8;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    localparam logic [5:0]  SEC_MAX    = 6'd59;
    localparam logic [5:0]  MIN_MAX    = 6'd59;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [3:0]  MONTH_MAX  = 4'd11;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;

    localparam logic [4:0]  HOUR_RESET  = 5'd15;
    localparam logic [4:0]  DAY_RESET   = 5'd11;
    localparam logic [3:0]  MONTH_RESET = 4'd11;
    localparam logic [15:0] YEAR_RESET  = 16'd1995;

    localparam logic [3:0]  MONTH_FEB = 4'd1;
    localparam logic [3:0]  MONTH_APR = 4'd3;
    localparam logic [3:0]  MONTH_JUN = 4'd5;
    localparam logic [3:0]  MONTH_SEP = 4'd8;
    localparam logic [3:0]  MONTH_NOV = 4'd10;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } time_t;

    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        days = 5'd31;
        case (month) inside
            MONTH_FEB:                                  days = 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
            default:                                    days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

### hdl/ccc_timekeep.sv
// ----------------------------------------------------------------------------
// Calendar clock counter time keeper
// Tick prescaler, rate register and calendar registers with next-time logic.
// ----------------------------------------------------------------------------
module ccc_timekeep
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [ccc_pkg::TPS_W-1:0] cfg_wr_data,
    input  logic                    advance,
    output ccc_pkg::time_t          time_now,
    output logic                    pulse
);
    import ccc_pkg::*;

    logic [TPS_W-1:0] tps_reg;
    logic [TPS_W-1:0] count_reg;
    logic [TPS_W-1:0] count_next;
    logic [TPS_W:0]   count_inc;
    logic             wrap;
    time_t            time_reg;
    time_t            time_next;

    always_comb
    begin
        count_inc  = {1'b0, count_reg} + {{TPS_W{1'b0}}, 1'b1};
        wrap       = count_inc >= {1'b0, tps_reg};
        pulse      = advance && wrap;
        count_next = count_reg;
        if (advance)
        begin
            count_next = wrap ? '0 : count_inc[TPS_W-1:0];
        end

        time_next = time_reg;
        if (pulse)
        begin
            if (time_reg.second < SEC_MAX)
            begin
                time_next.second = time_reg.second + 6'd1;
            end
            else
            begin
                time_next.second = '0;
                if (time_reg.minute < MIN_MAX)
                begin
                    time_next.minute = time_reg.minute + 6'd1;
                end
                else
                begin
                    time_next.minute = '0;
                    if (time_reg.hour < HOUR_MAX)
                    begin
                        time_next.hour = time_reg.hour + 5'd1;
                    end
                    else
                    begin
                        time_next.hour = '0;
                        if (time_reg.day < month_days(time_reg.month))
                        begin
                            time_next.day = time_reg.day + 5'd1;
                        end
                        else
                        begin
                            time_next.day = DAY_FIRST;
                            if (time_reg.month < MONTH_MAX)
                            begin
                                time_next.month = time_reg.month + 4'd1;
                            end
                            else
                            begin
                                time_next.month = '0;
                                time_next.year  = time_reg.year + 16'd1;
                            end
                        end
                    end
                end
            end
        end
        time_now = time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= TPS_RESET;
            count_reg      <= '0;
            time_reg.second <= '0;
            time_reg.minute <= '0;
            time_reg.hour   <= HOUR_RESET;
            time_reg.day    <= DAY_RESET;
            time_reg.month  <= MONTH_RESET;
            time_reg.year   <= YEAR_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tps_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            time_reg  <= time_next;
        end
    end

endmodule

### hdl/calendar_clock_counter_core.sv
// ----------------------------------------------------------------------------
// Calendar clock counter core
// Counts ticks into seconds and advances a time-of-day and date calendar.
// Each input word carries one tick flag and yields one output word with the
// time after that tick and a seconds pulse. A new word is taken every clock
// cycle unless the output stalls: the prescaler and calendar update is a
// single pass of compares and increments ahead of the output register, so
// throughput is one word per cycle and each output word is registered in
// the cycle after its input is taken. s_tready falls only while the output
// register holds a word m_tready has not taken. ticks_per_second 0 acts as 1.
// ----------------------------------------------------------------------------
module calendar_clock_counter_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ccc_pkg::TPS_W-1:0]     cfg_wr_data,     // ticks_per_second
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ccc_pkg::S_TDATA_W-1:0] s_tdata,         // tick[0], zero[7:1]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // second[5:0] minute[11:6] hour[16:12] day[21:17] month[25:22]
    // year[41:26] second_pulse[42] zero[47:43]
    output logic [ccc_pkg::M_TDATA_W-1:0] m_tdata
);
    import ccc_pkg::*;

    logic                 s_accept;
    logic                 advance;
    time_t                time_now;
    logic                 pulse;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign advance  = s_accept && s_tdata[0];

    ccc_timekeep u_timekeep
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .time_now    (time_now),
        .pulse       (pulse)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s_accept)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_data_reg <= {{(M_TDATA_W - $bits(time_t) - 1){1'b0}}, pulse, time_now};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hdl/ccc_checker.sv
// ----------------------------------------------------------------------------
// Calendar clock counter port checker
// Watches the top-level ports for handshake and calendar range violations.
// ----------------------------------------------------------------------------
`include "calendar_clock_counter_core_defines.svh"

module ccc_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ccc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ccc_pkg::M_TDATA_W-1:0] m_tdata
);
    import ccc_pkg::*;

    logic out_stall;
    logic idle_accept;
    logic range_ok;

    assign out_stall   = m_tvalid && !m_tready;
    assign idle_accept = s_tvalid && s_tready && !s_tdata[0];
    assign range_ok    = (m_tdata[5:0] <= SEC_MAX) && (m_tdata[11:6] <= MIN_MAX)
                         && (m_tdata[16:12] <= HOUR_MAX) && (m_tdata[21:17] >= DAY_FIRST)
                         && (m_tdata[25:22] <= MONTH_MAX);

    `CCC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled word changed")
    `CCC_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
    `CCC_ASSERT_NEXT(a_no_tick_no_pulse, idle_accept, m_tvalid && !m_tdata[42], "stray pulse")
    `CCC_ASSERT_SAME(a_calendar_range, m_tvalid, range_ok, "calendar field out of range")

endmodule

bind calendar_clock_counter_core ccc_checker u_ccc_checker (.*);
